>>> design/tpa_pkg.sv
// Shared types, constants and helper functions of the two-point angle block.
`default_nettype none

package tpa_pkg;

  // Field widths and format of the result
  localparam int COORD_WIDTH   = 16;
  localparam int FRAC_BITS     = 13;
  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_W       = 16;

  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int MAG_W    = COORD_WIDTH;
  localparam int INT_FRAC = 30;
  localparam int PRE_SHIFT = 60 - COORD_WIDTH;

  // Keep every bit of the micro-rotations: truncation below the pre-shift moves the
  // sign decisions. Magnitudes below 2^60 grow by the CORDIC gain, under 2^62.
  localparam int XY_W     = 63;
  localparam int INIT_SH  = PRE_SHIFT;
  localparam int Z_W      = 32;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint TWO_PI_Q30  = 64'd6746518852;

  localparam int     RND_SH      = INT_FRAC - FRAC_BITS;
  localparam longint RND_HALF    = 64'd1 << (RND_SH - 1);
  localparam longint FULL_ROUND  = (TWO_PI_Q30 + RND_HALF) >> RND_SH;
  localparam longint DEGEN_ROUND = (HALF_PI_Q30 + RND_HALF) >> RND_SH;

  localparam int A_W     = 33;
  localparam int THETA_W = 31;
  localparam int SUM_W   = A_W + 1;
  localparam int R_W     = SUM_W - RND_SH;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
  } tpa_in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               degenerate;
  } tpa_out_t;

  // Quadrant and special-case flags that ride along with the CORDIC datapath
  typedef struct packed {
    logic vx_neg;
    logic vy_neg;
    logic degen;
  } tpa_flags_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [Z_W-1:0] tpa_atan(input int idx);
    logic signed [Z_W-1:0] val;
    unique case (idx)
      0:  val = 32'sh3243F6A8;
      1:  val = 32'sh1DAC6705;
      2:  val = 32'sh0FADBAFC;
      3:  val = 32'sh07F56EA6;
      4:  val = 32'sh03FEAB76;
      5:  val = 32'sh01FFD55B;
      6:  val = 32'sh00FFFAAA;
      7:  val = 32'sh007FFF55;
      8:  val = 32'sh003FFFEA;
      9:  val = 32'sh001FFFFD;
      10: val = 32'sh000FFFFF;
      11: val = 32'sh0007FFFF;
      12: val = 32'sh0003FFFF;
      13: val = 32'sh0001FFFF;
      14: val = 32'sh0000FFFF;
      15: val = 32'sh00007FFF;
      16: val = 32'sh00003FFF;
      17: val = 32'sh00001FFF;
      18: val = 32'sh00000FFF;
      19: val = 32'sh000007FF;
      20: val = 32'sh000003FF;
      21: val = 32'sh000001FF;
      22: val = 32'sh000000FF;
      23: val = 32'sh0000007F;
      24: val = 32'sh0000003F;
      25: val = 32'sh0000001F;
      26: val = 32'sh0000000F;
      27: val = 32'sh00000008;
      28: val = 32'sh00000004;
      29: val = 32'sh00000002;
      30: val = 32'sh00000001;
      default: val = '0;
    endcase
    return val;
  endfunction

  // Right shift that rounds toward zero
  function automatic logic signed [XY_W-1:0] tpa_sshr(input logic signed [XY_W-1:0] v,
                                                      input int s);
    logic signed [XY_W-1:0] fl;
    logic [XY_W-1:0]        low_mask;
    fl       = v >>> s;
    low_mask = ~({XY_W{1'b1}} << s);
    if (v[XY_W-1] && ((v & low_mask) != '0)) begin
      return fl + XY_W'(1);
    end
    return fl;
  endfunction

endpackage

`default_nettype wire

>>> design/tpa_prep.sv
// Front end: coordinate differences, then magnitudes and quadrant flags.
`default_nettype none

module tpa_prep import tpa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire tpa_in_t          in_data,
  output logic                  mag_valid,
  output logic [MAG_W-1:0]      mag_x,
  output logic [MAG_W-1:0]      mag_y,
  output tpa_flags_t            flags
);

  logic                     diff_valid_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic                     mag_valid_r;
  logic [MAG_W-1:0]         mag_x_r, mag_y_r, mag_x_nxt, mag_y_nxt;
  tpa_flags_t               flags_r, flags_nxt;
  logic signed [DIFF_W-1:0] abs_x, abs_y;

  always_comb begin
    dx_nxt = {in_data.second_x[COORD_WIDTH-1], in_data.second_x}
           - {in_data.first_x[COORD_WIDTH-1], in_data.first_x};
    dy_nxt = {in_data.second_y[COORD_WIDTH-1], in_data.second_y}
           - {in_data.first_y[COORD_WIDTH-1], in_data.first_y};
  end

  // vx = dx, vy = -dy (screen y points down)
  always_comb begin
    abs_x     = dx_r[DIFF_W-1] ? -dx_r : dx_r;
    abs_y     = dy_r[DIFF_W-1] ? -dy_r : dy_r;
    mag_x_nxt = abs_x[MAG_W-1:0];
    mag_y_nxt = abs_y[MAG_W-1:0];
    flags_nxt.vx_neg = dx_r[DIFF_W-1];
    flags_nxt.vy_neg = !dy_r[DIFF_W-1] && (dy_r != '0);
    flags_nxt.degen  = (dx_r == '0) && (dy_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_valid_r <= 1'b0;
      mag_valid_r  <= 1'b0;
    end else if (en) begin
      diff_valid_r <= in_valid;
      mag_valid_r  <= diff_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      mag_x_r <= mag_x_nxt;
      mag_y_r <= mag_y_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign mag_valid = mag_valid_r;
  assign mag_x     = mag_x_r;
  assign mag_y     = mag_y_r;
  assign flags     = flags_r;

endmodule

`default_nettype wire

>>> design/tpa_cordic.sv
// Unrolled vectoring CORDIC, one registered micro-rotation per stage.
`default_nettype none

module tpa_cordic import tpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [MAG_W-1:0]  mag_x,
  input  wire logic [MAG_W-1:0]  mag_y,
  input  wire tpa_flags_t        in_flags,
  output logic                   z_valid,
  output logic signed [Z_W-1:0]  z,
  output tpa_flags_t             out_flags
);

  logic signed [XY_W-1:0] x_r [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_r [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_r [CORDIC_STAGES];
  tpa_flags_t             f_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] v_r;

  logic signed [XY_W-1:0] x_init, y_init;

  assign x_init = XY_W'(mag_x) << INIT_SH;
  assign y_init = XY_W'(mag_y) << INIT_SH;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XY_W-1:0] x_src, y_src, xs, ys, x_nxt, y_nxt;
    logic signed [Z_W-1:0]  z_src, z_nxt;
    tpa_flags_t             f_src;
    logic                   v_src;

    if (i == 0) begin : g_first
      assign x_src = x_init;
      assign y_src = y_init;
      assign z_src = '0;
      assign f_src = in_flags;
      assign v_src = in_valid;
    end else begin : g_next
      assign x_src = x_r[i-1];
      assign y_src = y_r[i-1];
      assign z_src = z_r[i-1];
      assign f_src = f_r[i-1];
      assign v_src = v_r[i-1];
    end

    // Rotate toward the x axis: clockwise while y is not negative
    always_comb begin
      xs = tpa_sshr(x_src, i);
      ys = tpa_sshr(y_src, i);
      if (!y_src[XY_W-1]) begin
        x_nxt = x_src + ys;
        y_nxt = y_src - xs;
        z_nxt = z_src + tpa_atan(i);
      end else begin
        x_nxt = x_src - ys;
        y_nxt = y_src + xs;
        z_nxt = z_src - tpa_atan(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        f_r[i] <= f_src;
      end
    end
  end

  assign z_valid   = v_r[CORDIC_STAGES-1];
  assign z         = z_r[CORDIC_STAGES-1];
  assign out_flags = f_r[CORDIC_STAGES-1];

endmodule

`default_nettype wire

>>> design/tpa_post.sv
// Back end: clamp, undo the quadrant fold, round and wrap into one turn; coincident points give pi/2.
`default_nettype none

module tpa_post import tpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              z_valid,
  input  wire logic signed [Z_W-1:0] z,
  input  wire tpa_flags_t        flags,
  output logic                   out_valid,
  output tpa_out_t               out_data
);

  logic               a_valid_r;
  logic [A_W-1:0]     a_r, a_nxt;
  logic               degen_r;
  logic               out_valid_r;
  tpa_out_t           out_r, out_nxt;
  logic [THETA_W-1:0] theta;
  logic [SUM_W-1:0]   sum;
  logic [R_W-1:0]     r_raw, r_wrap;

  // Clamp the first-quadrant angle to [0, pi/2], then place it in its quadrant
  always_comb begin
    if (z[Z_W-1]) begin
      theta = '0;
    end else if (longint'(z) > HALF_PI_Q30) begin
      theta = THETA_W'(HALF_PI_Q30);
    end else begin
      theta = z[THETA_W-1:0];
    end
    unique case ({flags.vy_neg, flags.vx_neg})
      2'b00:   a_nxt = A_W'(theta);
      2'b01:   a_nxt = A_W'(PI_Q30) - A_W'(theta);
      2'b11:   a_nxt = A_W'(PI_Q30) + A_W'(theta);
      default: a_nxt = A_W'(TWO_PI_Q30) - A_W'(theta);
    endcase
  end

  // Round half up, fold a full turn back to zero
  always_comb begin
    sum    = SUM_W'(a_r) + SUM_W'(RND_HALF);
    r_raw  = sum[SUM_W-1:RND_SH];
    r_wrap = (r_raw >= R_W'(FULL_ROUND)) ? (r_raw - R_W'(FULL_ROUND)) : r_raw;
    if (degen_r) begin
      out_nxt.angle      = ANGLE_W'(DEGEN_ROUND);
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.angle      = ANGLE_W'(r_wrap);
      out_nxt.degenerate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= z_valid;
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r     <= a_nxt;
      degen_r <= flags.degen;
      out_r   <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> design/two_point_angle_core.sv
// Top level of the two-point direction angle pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one request: two
//   signed pixel points. Result channel (out_valid / out_stall / out_data)
//   returns the direction atan2(-dy, dx) in [0, 2*pi) as unsigned radians
//   with FRAC_BITS fraction bits, plus a flag set when the points coincide.
//   A request is taken at a clock edge where valid is high and stall low.
//   Throughput: one request per cycle while the receiver does not stall a shown result.
//   Depth: 2 front-end stages, CORDIC_STAGES micro-rotation stages and
//   2 back-end stages; the unrolled CORDIC chain makes up most of the
//   depth.
//   Reset (rst_n low, synchronous) empties the pipeline: all valid bits
//   clear, out_valid drops, and in_stall releases.
//   When the receiver stalls while a result is showing, the whole pipeline
//   holds in place and in_stall rises in the same cycle; nothing is dropped
//   or repeated. Empty output slots never hold the pipeline.
`default_nettype none

module two_point_angle_core import tpa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tpa_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tpa_out_t      out_data
);

  logic               en;
  logic               mag_valid;
  logic [MAG_W-1:0]   mag_x, mag_y;
  tpa_flags_t         mag_flags;
  logic               z_valid;
  logic signed [Z_W-1:0] z;
  tpa_flags_t         z_flags;

  // Advance every stage unless a finished result is held by the receiver
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  tpa_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .mag_valid (mag_valid),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .flags     (mag_flags)
  );

  tpa_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mag_valid),
    .mag_x     (mag_x),
    .mag_y     (mag_y),
    .in_flags  (mag_flags),
    .z_valid   (z_valid),
    .z         (z),
    .out_flags (z_flags)
  );

  tpa_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .z_valid   (z_valid),
    .z         (z),
    .flags     (z_flags),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the two-point direction angle pipeline.
`timescale 1ns / 100ps

module testbench;

  localparam int CW = tpa_pkg::COORD_WIDTH;
  localparam int AW = tpa_pkg::ANGLE_W;

  // Angle constants in radians scaled by 2^30
  localparam longint HALF_TURN_Q30    = 64'sd3373259426;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint FULL_TURN_Q30    = 64'sd6746518852;
  localparam int     VEC_SHIFT        = 60 - CW;
  localparam int     ROUND_SH         = 30 - tpa_pkg::FRAC_BITS;
  localparam longint ROUND_HALF       = 64'sd1 << (ROUND_SH - 1);

  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SHOWN_LIMIT  = 10;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  tpa_pkg::tpa_in_t in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  tpa_pkg::tpa_out_t out_data;

  // atan(2^-i) scaled by 2^30, truncated
  longint atan_q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  tpa_pkg::tpa_out_t pending_directions [$];
  int                mismatch_count = 0;
  int                quiet_cycles   = 0;
  int                send_idle_pct  = 0;
  int                stall_pct      = 0;

  two_point_angle_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shift right, rounding the magnitude toward zero
  function automatic longint shift_toward_zero(input longint v, input int s);
    if (v < 0) begin
      return -longint'(longint'(-v) >> s);
    end
    return v >> s;
  endfunction

  // Direction of (second - first) with y pointing down, in [0, 2*pi)
  function automatic tpa_pkg::tpa_out_t predict_direction(input tpa_pkg::tpa_in_t req);
    longint dx, dy, vx, vy, x, y, z, xs, ys, a, r, full;
    tpa_pkg::tpa_out_t res;
    int i;
    dx = longint'($signed(req.second_x)) - longint'($signed(req.first_x));
    dy = longint'($signed(req.second_y)) - longint'($signed(req.first_y));
    if (dx == 0 && dy == 0) begin
      res.angle      = AW'((QUARTER_TURN_Q30 + ROUND_HALF) >> ROUND_SH);
      res.degenerate = 1'b1;
      return res;
    end
    vx = dx;
    vy = -dy;
    // fold into the first quadrant, then rotate the vector onto the x axis
    x = (vx < 0 ? -vx : vx) << VEC_SHIFT;
    y = (vy < 0 ? -vy : vy) << VEC_SHIFT;
    z = 0;
    for (i = 0; i < tpa_pkg::CORDIC_STAGES && i < 32; i++) begin
      xs = shift_toward_zero(x, i);
      ys = shift_toward_zero(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q30[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q30[i];
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_TURN_Q30) z = QUARTER_TURN_Q30;
    // undo the fold
    if (vy >= 0) begin
      a = (vx >= 0) ? z : HALF_TURN_Q30 - z;
    end else begin
      a = (vx < 0) ? HALF_TURN_Q30 + z : FULL_TURN_Q30 - z;
    end
    r    = (a + ROUND_HALF) >> ROUND_SH;
    full = (FULL_TURN_Q30 + ROUND_HALF) >> ROUND_SH;
    if (r >= full) r = r - full;
    res.angle      = AW'(r);
    res.degenerate = 1'b0;
    return res;
  endfunction

  function automatic tpa_pkg::tpa_in_t points(input int fx, input int fy,
                                             input int sx, input int sy);
    tpa_pkg::tpa_in_t p;
    p.first_x  = CW'(fx);
    p.first_y  = CW'(fy);
    p.second_x = CW'(sx);
    p.second_y = CW'(sy);
    return p;
  endfunction

  // Mostly well-spread random pairs, with a share of axis, diagonal, short and
  // coincident vectors so every octant boundary gets exercised
  function automatic tpa_pkg::tpa_in_t random_pair();
    tpa_pkg::tpa_in_t p;
    logic [CW-1:0] d;
    p = {$urandom, $urandom};
    d = CW'($urandom);
    case ($urandom_range(0, 11))
      0: begin
        p.second_x = p.first_x;
        p.second_y = p.first_y;
      end
      1: p.second_y = p.first_y;
      2: p.second_x = p.first_x;
      3, 4: begin
        p.second_x = p.first_x + CW'($urandom_range(0, 8)) - CW'(4);
        p.second_y = p.first_y + CW'($urandom_range(0, 8)) - CW'(4);
      end
      5: begin
        p.second_x = p.first_x + d;
        p.second_y = $urandom_range(0, 1) ? p.first_y + d : p.first_y - d;
      end
      6: p.second_y = p.first_y + CW'($urandom_range(0, 2)) - CW'(1);
      default: ;
    endcase
    return p;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_LIMIT) $display("mismatch: %s", msg);
  endfunction

  // Hold the request until it is taken, then record what it must produce
  task automatic send_point_pair(input tpa_pkg::tpa_in_t req);
    bit taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_stall === 1'b0);
      @(posedge clk);
    end
    pending_directions.push_back(predict_direction(req));
  endtask

  task automatic test_coincident_points();
    send_point_pair(points(0, 0, 0, 0));
    send_point_pair(points(-32768, -32768, -32768, -32768));
    send_point_pair(points(32767, 32767, 32767, 32767));
    send_point_pair(points(1234, -77, 1234, -77));
  endtask

  task automatic test_axis_directions();
    send_point_pair(points(0, 0, 1, 0));
    send_point_pair(points(-32768, 5, 32767, 5));
    send_point_pair(points(0, 0, -1, 0));
    send_point_pair(points(32767, -9, -32768, -9));
    send_point_pair(points(0, 0, 0, 1));
    send_point_pair(points(3, -32768, 3, 32767));
    send_point_pair(points(0, 0, 0, -1));
    send_point_pair(points(-3, 32767, -3, -32768));
    // just below the x axis: rounds up to a full turn and wraps to zero
    send_point_pair(points(-32768, 0, 32767, 1));
  endtask

  task automatic test_quadrant_diagonals();
    send_point_pair(points(-32768, -32768, 32767, 32767));
    send_point_pair(points(32767, 32767, -32768, -32768));
    send_point_pair(points(-32768, 32767, 32767, -32768));
    send_point_pair(points(32767, -32768, -32768, 32767));
    send_point_pair(points(0, 0, 1, 1));
    send_point_pair(points(0, 0, -1, 1));
    send_point_pair(points(0, 0, 1, -1));
    send_point_pair(points(0, 0, -1, -1));
  endtask

  task automatic test_random_stream(input int count, input int idle_pct, input int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    repeat (count) send_point_pair(random_pair());
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare each taken result with the oldest outstanding prediction
  always @(negedge clk) begin
    tpa_pkg::tpa_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_directions.size() == 0) begin
        note_failure($sformatf("unexpected result angle=%0d degenerate=%0b",
                               out_data.angle, out_data.degenerate));
      end else begin
        want = pending_directions.pop_front();
        if (out_data.angle !== want.angle || out_data.degenerate !== want.degenerate) begin
          note_failure($sformatf("angle exp=%0d got=%0d, degenerate exp=%0b got=%0b",
                                 want.angle, out_data.angle,
                                 want.degenerate, out_data.degenerate));
        end
      end
    end
  end

  // Abort when no handshake happens on either side for too long
  always @(negedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_coincident_points();
    test_axis_directions();
    test_quadrant_diagonals();
    test_random_stream(200, 0, 0);
    test_random_stream(200, 78, 0);
    test_random_stream(200, 0, 78);
    test_random_stream(200, 38, 38);
    in_valid <= 1'b0;
    while (pending_directions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> two_point_angle_core.f
design/tpa_pkg.sv
design/tpa_prep.sv
design/tpa_cordic.sv
design/tpa_post.sv
design/two_point_angle_core.sv
dv/testbench.sv
